FILE: rtl/e2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and tables for the epoch-to-calendar converter
// Holds the controller/datapath command and status structures, the field
// widths and the calendar tables (month lengths, month keys, leap rule).
// ----------------------------------------------------------------------------
package e2c_pkg;

   // Field widths of the input and result items.
   localparam int EPOCH_W = 32;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int MDAY_W  = 5;
   localparam int YDAY_W  = 9;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int WDAY_W  = 3;

   // Packed result width, padded to whole bytes.
   localparam int RES_BITS = YEAR_W + MONTH_W + MDAY_W + YDAY_W + HOUR_W + MIN_W + SEC_W +
                             WDAY_W;
   localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

   // Width of the remainder once whole years are gone (below 366 days of seconds).
   localparam int SOY_W   = 25;

   localparam logic [YEAR_W-1:0]  FIRST_YEAR      = 12'd1970;
   localparam logic [EPOCH_W-1:0] SECS_YEAR_PLAIN = 32'd31536000;
   localparam logic [EPOCH_W-1:0] SECS_YEAR_LEAP  = 32'd31622400;
   localparam logic [16:0]        SECS_PER_DAY    = 17'd86400;
   localparam logic [16:0]        SECS_PER_HOUR   = 17'd3600;
   localparam logic [16:0]        SECS_PER_MIN    = 17'd60;

   // Reciprocals for the quotients. The dividend is first shifted right by
   // the power of two in the divisor (7, 4 and 2 bits), then multiplied and
   // shifted right by 28, 20 and 14 bits. Each is exact over its range.
   localparam logic [18:0] DAY_RECIP  = 19'd397683;  // 2^28 / 675, rounded up
   localparam logic [12:0] HOUR_RECIP = 13'd4661;    // 2^20 / 225, rounded up
   localparam logic [10:0] MIN_RECIP  = 11'd1093;    // 2^14 / 15, rounded up

   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_YEAR,
      OP_QUOT,
      OP_REM,
      OP_MSTART,
      OP_MONTH,
      OP_WDAY
   } op_type;

   typedef enum logic [1:0] {
      SEL_DAY,
      SEL_HOUR,
      SEL_MIN
   } sel_type;

   typedef struct packed {
      op_type              op;
      sel_type             sel;
   } cmd_type;

   typedef struct packed {
      logic year_fit;
      logic month_fit;
   } sts_type;

   // Gregorian leap rule. Years stay within 1970..2106, where the only
   // centuries are 2000 (a leap year, multiple of 400) and 2100 (not leap).
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      return (y[1:0] == 2'b00) && (y != 12'd2100);
   endfunction

   function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [MDAY_W-1:0] len;
      case (m)
         4'd1:                    len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] month_key(input logic [MONTH_W-1:0] m);
      logic [2:0] key;
      case (m)
         4'd0:       key = 3'd1;
         4'd1, 4'd2: key = 3'd4;
         4'd3, 4'd6: key = 3'd0;
         4'd4:       key = 3'd2;
         4'd5:       key = 3'd5;
         4'd7:       key = 3'd3;
         4'd8:       key = 3'd6;
         4'd9:       key = 3'd1;
         4'd10:      key = 3'd4;
         default:    key = 3'd6;
      endcase
      return key;
   endfunction

   // Remainder modulo 7 of a key value, by five compare-and-subtract steps.
   function automatic logic [2:0] mod7(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      for (int k = 4; k >= 0; k--) begin
         if (r >= (8'd7 << k)) begin
            r = r - (8'd7 << k);
         end
      end
      return r[2:0];
   endfunction

endpackage

FILE: rtl/e2c_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_ctrl: conversion sequencer
// Steps the datapath through the year loop, the day, hour and minute
// divisions, the month walk and the weekday sum, then hands the result over.
// ----------------------------------------------------------------------------
module e2c_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  e2c_pkg::sts_type  sts,
   input  logic              out_free,
   output e2c_pkg::cmd_type  cmd,
   output logic              emit
);
   import e2c_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_YEAR,
      S_QUOT,
      S_REM,
      S_MSTART,
      S_MONTH,
      S_WDAY,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   sel_type            sel_ff, sel_in;

   // Commands for the current state.
   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      cmd.op     = OP_NONE;
      cmd.sel    = sel_ff;
      req_tready = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            if (sts.year_fit) begin
               sel_in   = SEL_DAY;
               state_in = S_QUOT;
            end else begin
               cmd.op = OP_YEAR;
            end
         end
         // Each division takes a quotient state and a remainder state.
         S_QUOT: begin
            cmd.op   = OP_QUOT;
            state_in = S_REM;
         end
         S_REM: begin
            cmd.op = OP_REM;
            unique case (sel_ff)
               SEL_DAY: begin
                  sel_in   = SEL_HOUR;
                  state_in = S_QUOT;
               end
               SEL_HOUR: begin
                  sel_in   = SEL_MIN;
                  state_in = S_QUOT;
               end
               default: begin
                  state_in = S_MSTART;
               end
            endcase
         end
         S_MSTART: begin
            cmd.op   = OP_MSTART;
            state_in = S_MONTH;
         end
         S_MONTH: begin
            if (sts.month_fit) begin
               state_in = S_WDAY;
            end else begin
               cmd.op = OP_MONTH;
            end
         end
         S_WDAY: begin
            cmd.op   = OP_WDAY;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and division selector registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= SEL_DAY;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

FILE: rtl/e2c_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_dpath: conversion datapath
// Holds the remaining seconds, the year, the quotients found by reciprocal
// multiplication, the month walk registers and the weekday key value.
// ----------------------------------------------------------------------------
module e2c_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  e2c_pkg::cmd_type                cmd,
   input  logic [e2c_pkg::EPOCH_W-1:0]     epoch_seconds,
   output e2c_pkg::sts_type                sts,
   output logic [e2c_pkg::RES_W-1:0]       result
);
   import e2c_pkg::*;

   logic [EPOCH_W-1:0] rem_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [YDAY_W-1:0]  days_ff;
   logic [HOUR_W-1:0]  hour_ff;
   logic [MIN_W-1:0]   minute_ff;
   logic [YDAY_W-1:0]  yday_ff;
   logic [YDAY_W-1:0]  left_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [7:0]         key_ff;

   logic               leap;
   logic [EPOCH_W-1:0] year_secs;
   logic [36:0]        day_prod;
   logic [24:0]        hour_prod;
   logic [19:0]        min_prod;
   logic [SOY_W-1:0]   rem_sub;
   logic [YDAY_W-1:0]  mlen;
   logic [6:0]         yy;
   logic [2:0]         century_key;
   logic [7:0]         key_sum;
   logic [2:0]         key_mod;
   logic [WDAY_W-1:0]  weekday;

   // Year length, month length and the loop exit tests.
   always_comb begin
      leap      = is_leap(year_ff);
      year_secs = leap ? SECS_YEAR_LEAP : SECS_YEAR_PLAIN;
      mlen      = YDAY_W'(month_len(month_ff)) +
                  YDAY_W'((month_ff == FEBRUARY) && leap);
      sts.year_fit  = rem_ff < year_secs;
      sts.month_fit = left_ff <= mlen;
   end

   // Quotients by reciprocal multiplication, and the amount that each
   // stored quotient takes off the remaining seconds.
   always_comb begin
      day_prod  = 37'(rem_ff[SOY_W-1:7]) * 37'(DAY_RECIP);
      hour_prod = 25'(rem_ff[16:4]) * 25'(HOUR_RECIP);
      min_prod  = 20'(rem_ff[11:2]) * 20'(MIN_RECIP);
      case (cmd.sel)
         SEL_DAY:  rem_sub = SOY_W'(days_ff) * SOY_W'(SECS_PER_DAY);
         SEL_HOUR: rem_sub = SOY_W'(hour_ff) * SOY_W'(SECS_PER_HOUR);
         default:  rem_sub = SOY_W'(minute_ff) * SOY_W'(SECS_PER_MIN);
      endcase
   end

   // Key value of the weekday: year within the century and the century code.
   always_comb begin
      if (year_ff < 12'd2000) begin
         yy          = 7'(year_ff - 12'd1900);
         century_key = 3'd0;
      end else if (year_ff < 12'd2100) begin
         yy          = 7'(year_ff - 12'd2000);
         century_key = 3'd6;
      end else begin
         yy          = 7'(year_ff - 12'd2100);
         century_key = 3'd4;
      end
      key_sum = 8'(yy[6:2]) + 8'(left_ff[MDAY_W-1:0]) + 8'(month_key(month_ff)) +
                8'(century_key) + 8'(yy) - 8'(leap && (month_ff <= FEBRUARY));
   end

   // Datapath registers, updated by the command of the sequencer.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            rem_ff    <= epoch_seconds;
            year_ff   <= FIRST_YEAR;
            days_ff   <= '0;
            hour_ff   <= '0;
            minute_ff <= '0;
         end
         OP_YEAR: begin
            rem_ff  <= rem_ff - year_secs;
            year_ff <= year_ff + 1'b1;
         end
         OP_QUOT: begin
            case (cmd.sel)
               SEL_DAY:  days_ff   <= day_prod[36:28];
               SEL_HOUR: hour_ff   <= hour_prod[24:20];
               default:  minute_ff <= min_prod[19:14];
            endcase
         end
         OP_REM: begin
            rem_ff <= rem_ff - EPOCH_W'(rem_sub);
         end
         OP_MSTART: begin
            yday_ff  <= days_ff + 1'b1;
            left_ff  <= days_ff + 1'b1;
            month_ff <= '0;
         end
         OP_MONTH: begin
            left_ff  <= left_ff - mlen;
            month_ff <= month_ff + 1'b1;
         end
         OP_WDAY: begin
            key_ff <= key_sum;
         end
         default: begin
         end
      endcase
   end

   // Key value 1 is Sunday and 0 is Saturday.
   always_comb begin
      key_mod = mod7(key_ff);
      weekday = (key_mod != 3'd0) ? (key_mod - 3'd1) : 3'd6;
   end

   // Result packed from the lowest bit up.
   assign result = RES_W'({weekday, rem_ff[SEC_W-1:0], minute_ff, hour_ff, yday_ff,
                           left_ff[MDAY_W-1:0], month_ff, year_ff});

   property p_year_bound;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_YEAR) |=> (year_ff <= 12'd2106);
   endproperty
   a_year_bound: assert property (p_year_bound)
      else $error("Year count ran past the end of the 32-bit range.");

   property p_div_narrow;
      @(posedge clock) disable iff (reset)
         ((cmd.op == OP_QUOT) || (cmd.op == OP_REM)) |-> (rem_ff[EPOCH_W-1:SOY_W] == '0);
   endproperty
   a_div_narrow: assert property (p_div_narrow)
      else $error("Division started before whole years were removed.");

   property p_month_bound;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_MONTH) |-> (month_ff < 4'd11);
   endproperty
   a_month_bound: assert property (p_month_bound)
      else $error("Month walk went beyond December.");

   property p_sec_range;
      @(posedge clock) disable iff (reset)
         (cmd.op == OP_WDAY) |-> (rem_ff < 32'd60) && (hour_ff < 5'd24) &&
                                 (minute_ff < 6'd60);
   endproperty
   a_sec_range: assert property (p_sec_range)
      else $error("Time of day out of range after the divisions.");

endmodule

FILE: rtl/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to calendar date and time
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00
// into year, month, day, day of year, hour, minute, second and weekday.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one item, the 32-bit epoch count, on req_tdata.
//   The rsp_ channel returns one item per input item with every calendar
//   field packed into rsp_tdata.
//   After the item is taken the sequencer finds the year in a loop, then runs
//   the day, hour and minute divisions (a quotient and a remainder step each,
//   by reciprocal multiplication), starts the month walk, walks the months,
//   forms the weekday and hands the result over.
//   The year loop, one year subtracted per cycle, sets most of the conversion time.
//   One item is converted at a time; req_tready is high only while the
//   sequencer is idle, so no new item is taken before the last is through.
//   The result sits in an output register, so a new item is taken while the
//   previous result still waits on a stalled receiver. A finished conversion
//   waits for that register to free before it is handed over.
//   Reset clears the sequencer and the output valid; nothing else needs it.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // epoch_seconds [31:0]
   input  logic [e2c_pkg::EPOCH_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // year [11:0], month [15:12], day_of_month [20:16], day_of_year [29:21],
   // hour [34:30], minute [40:35], second [46:41], weekday [49:47], zeros above
   output logic [e2c_pkg::RES_W-1:0]     rsp_tdata
);
   import e2c_pkg::*;

   cmd_type           cmd;
   sts_type           sts;
   logic              emit;
   logic              out_free;
   logic [RES_W-1:0]  result;
   logic              rsp_tvalid_ff;
   logic [RES_W-1:0]  rsp_tdata_ff;

   // The output register is free when empty or being taken this cycle.
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   e2c_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .out_free   (out_free),
      .cmd        (cmd),
      .emit       (emit)
   );

   e2c_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .epoch_seconds (req_tdata),
      .sts           (sts),
      .result        (result)
   );

   // Output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_tdata_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the epoch-to-calendar converter
// Drives epoch second counts into the request stream and checks every
// returned calendar item, field by field, against a date calculation kept in
// the bench. Covers field extremes, leap and century years, random counts,
// random idling on both streams and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import e2c_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 200;
   localparam int STUCK_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 600;
   localparam int RANDOM_ITEMS  = 600;
   localparam int STEADY_ITEMS  = 70;
   localparam int SECS_DAY      = 86400;

   // One calendar result, as the bench predicts it.
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [MDAY_W-1:0]  mday;
      logic [YDAY_W-1:0]  yday;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   sec;
      logic [WDAY_W-1:0]  wday;
   } calendar_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [EPOCH_W-1:0]   req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RES_W-1:0]     rsp_tdata;

   // Month lengths and weekday keys of the key-value method.
   int unsigned days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   int unsigned month_keys [12]    = '{1, 4, 4, 0, 2, 5, 0, 3, 6, 1, 4, 6};
   int unsigned century_codes [4]  = '{4, 2, 0, 6};

   calendar_type pending_dates [$];
   bit          sender_idles = 1'b1;
   bit          receiver_idles = 1'b1;
   int unsigned hold_off_cycles = 0;
   bit          hold_off_done = 1'b0;
   int unsigned items_sent = 0;
   int unsigned dates_checked = 0;
   int unsigned mismatches = 0;
   int unsigned stuck_cycles = 0;

   epoch_seconds_to_calendar dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLK_HALF clock = ~clock;

   // Gregorian leap rule in full, centuries included.
   function automatic bit leap_gregorian(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned year_seconds(input int unsigned y);
      return (leap_gregorian(y) ? 366 : 365) * SECS_DAY;
   endfunction

   // Calendar date and time of day for a count of seconds since 1970.
   function automatic calendar_type calendar_of(input logic [EPOCH_W-1:0] secs);
      calendar_type c;
      int unsigned rest, yr, sod, doy, acc, mlen, mon, mday, yy, key;
      bit          found;
      rest = secs;
      yr   = 1970;
      while (rest >= year_seconds(yr)) begin
         rest = rest - year_seconds(yr);
         yr++;
      end
      doy   = rest / SECS_DAY + 1;
      sod   = rest % SECS_DAY;
      mon   = 11;
      mday  = 1;
      acc   = 0;
      found = 1'b0;
      for (int i = 0; i < 12; i++) begin
         mlen = days_in_month[i] + ((i == 1 && leap_gregorian(yr)) ? 1 : 0);
         if (!found && acc + mlen >= doy) begin
            mon   = i;
            mday  = doy - acc;
            found = 1'b1;
         end
         acc += mlen;
      end
      // Key value: century codes repeat every 400 years, so 2100 takes the 1700 code.
      yy  = yr % 100;
      key = yy / 4 + mday + month_keys[mon] + century_codes[(yr / 100 + 3) % 4] + yy;
      if (leap_gregorian(yr) && mon <= 1) begin
         key = key - 1;
      end
      key = key % 7;
      c.year   = YEAR_W'(yr);
      c.month  = MONTH_W'(mon);
      c.mday   = MDAY_W'(mday);
      c.yday   = YDAY_W'(doy);
      c.hour   = HOUR_W'(sod / 3600);
      c.minute = MIN_W'((sod % 3600) / 60);
      c.sec    = SEC_W'(sod % 60);
      c.wday   = WDAY_W'((key == 0) ? 6 : key - 1);
      return c;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Offers one item after a random gap and records its expected date once taken.
   task automatic send_epoch(input logic [EPOCH_W-1:0] secs);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, 10) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= secs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_dates.push_back(calendar_of(secs));
      items_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Second, minute, hour and day rollovers, leap days and the top of the range.
   task automatic test_directed();
      send_epoch(32'd0);
      send_epoch(32'd1);
      send_epoch(32'd59);
      send_epoch(32'd60);
      send_epoch(32'd3599);
      send_epoch(32'd3600);
      send_epoch(32'd86399);
      send_epoch(32'd86400);
      send_epoch(32'd31535999);
      send_epoch(32'd31536000);
      send_epoch(32'd68169600);
      send_epoch(32'd94694399);
      send_epoch(32'd94694400);
      send_epoch(32'd946684800);
      send_epoch(32'd951782400);
      send_epoch(32'd951868800);
      send_epoch(32'd978307199);
      send_epoch(32'd4102444800);
      send_epoch(32'd4107455999);
      send_epoch(32'd4107542400);
      send_epoch(32'd2147483647);
      send_epoch(32'h8000_0000);
      send_epoch(32'hAAAA_AAAA);
      send_epoch(32'h5555_5555);
      send_epoch(32'hFFFF_FFFF);
   endtask

   // Random counts: the full range, windows round new year and the early years.
   task automatic test_random();
      longint      start, value;
      int unsigned target;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 3))
            0, 1: value = $urandom;
            2: begin
               target = $urandom_range(1970, 2106);
               start  = 0;
               for (int unsigned y = 1970; y < target; y++) begin
                  start += year_seconds(y);
               end
               value = start + longint'($urandom_range(0, 4 * SECS_DAY)) - 2 * SECS_DAY;
               if (value < 0) value = 0;
               if (value > 64'hFFFF_FFFF) value = 64'hFFFF_FFFF;
            end
            default: value = $urandom_range(0, 200000000);
         endcase
         send_epoch(value[EPOCH_W-1:0]);
      end
   endtask

   // The receiver holds off while items keep coming, so the block fills and stalls.
   task automatic test_hold_off();
      sender_idles    = 1'b0;
      hold_off_cycles = HOLD_CYCLES;
      for (int n = 0; n < 8; n++) begin
         send_epoch($urandom);
      end
      sender_idles = 1'b1;
   endtask

   // Back-to-back items with both streams always ready.
   task automatic test_steady_flow();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      for (int n = 0; n < STEADY_ITEMS; n++) begin
         send_epoch($urandom);
      end
      stop_sending();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // Receiver: a random stall per item, or one long hold-off when requested.
   initial begin
      int unsigned stall;
      wait (!reset);
      forever begin
         stall = receiver_idles ? $urandom_range(0, 10) : 0;
         if (hold_off_cycles != 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
            hold_off_done   = 1'b1;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Each returned item is checked against the oldest expected date.
   always @(posedge clock) begin
      calendar_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result with no item outstanding", 1, 0);
         end else begin
            want = pending_dates.pop_front();
            dates_checked++;
            if (rsp_tdata[11:0] != want.year)
               report_mismatch("year", rsp_tdata[11:0], want.year);
            if (rsp_tdata[15:12] != want.month)
               report_mismatch("month", rsp_tdata[15:12], want.month);
            if (rsp_tdata[20:16] != want.mday)
               report_mismatch("day of month", rsp_tdata[20:16], want.mday);
            if (rsp_tdata[29:21] != want.yday)
               report_mismatch("day of year", rsp_tdata[29:21], want.yday);
            if (rsp_tdata[34:30] != want.hour)
               report_mismatch("hour", rsp_tdata[34:30], want.hour);
            if (rsp_tdata[40:35] != want.minute)
               report_mismatch("minute", rsp_tdata[40:35], want.minute);
            if (rsp_tdata[46:41] != want.sec)
               report_mismatch("second", rsp_tdata[46:41], want.sec);
            if (rsp_tdata[49:47] != want.wday)
               report_mismatch("weekday", rsp_tdata[49:47], want.wday);
            if (rsp_tdata[RES_W-1:50] != '0)
               report_mismatch("padding bits", rsp_tdata[RES_W-1:50], 0);
         end
      end
   end

   // Watchdog: ends the run when no item moves on either stream for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles", STUCK_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random();
      test_hold_off();
      test_steady_flow();

      while (pending_dates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_dates.size() != 0) begin
         report_mismatch("items left without a result", pending_dates.size(), 0);
      end

      $display("Converted %0d epoch counts, %0d dates checked, %0d mismatches.",
               items_sent, dates_checked, mismatches);
      $display("Leap and century years, range ends, idling and a %0d-cycle hold-off (%s).",
               HOLD_CYCLES, hold_off_done ? "done" : "missed");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
